// File: rtl/cjds_pkg.sv
`default_nettype none

package cjds_pkg;

    localparam int JOB_COUNT_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 5;
    localparam int BURST_W  = 8;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 13;
    localparam int POLICY_W = 2;
    localparam int SLICE_W  = 8;

    localparam int S_PAY_W   = INDEX_W + BURST_W + PRIO_W;
    localparam int S_TDATA_W = ((S_PAY_W + 7) / 8) * 8;
    localparam int M_PAY_W   = INDEX_W + TIME_W + BURST_W + 2;
    localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [TIME_W-1:0]  ELAPSED_MAX = '1;
    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD     = 2'd0,
        MODE_RESTART  = 2'd1,
        MODE_DISPATCH = 2'd2
    } mode_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FCFS = 2'd0,
        POL_SJF  = 2'd1,
        POL_PRIO = 2'd2,
        POL_RR   = 2'd3
    } policy_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLICY = 1'b0,
        CFG_SLICE  = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

// File: rtl/cpu_job_dispatch_scheduler_unit.sv
`default_nettype none

// Job dispatch scheduler. Jobs are loaded into a table of JOB_COUNT entries (burst and
// priority), a restart copies the bursts into the remaining-time memory, and each dispatch
// request returns one dispatch chosen by first come first served, shortest job first,
// priority or round robin. Every item gives exactly one result item, and the next item is
// accepted only once the unit is back in idle. The dispatch scans the remaining-time memory
// one entry per cycle through its single read port, and the restart sweeps it the same way.
// After reset a clearing pass zeroes every entry of the memories, during which no item is
// accepted. A new item is accepted while the previous result still waits on the output.
module cpu_job_dispatch_scheduler_unit #(
    parameter int JOB_COUNT = cjds_pkg::JOB_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [cjds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cjds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // job_index, job_burst, job_priority
    input  wire logic [cjds_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  wire logic [cjds_pkg::MODE_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // chosen_job, start_time, run_amount, job_finished, schedule_over
    output logic      [cjds_pkg::M_TDATA_W-1:0]    m_tdata,
    // dispatch_valid
    output logic      [0:0]                        m_tuser
);

    import cjds_pkg::*;

    localparam int IDX_W = $clog2(JOB_COUNT);
    localparam int CNT_W = $clog2(JOB_COUNT + 1);
    localparam logic [IDX_W:0]   JOB_COUNT_X = (IDX_W + 1)'(JOB_COUNT);
    localparam logic [CNT_W-1:0] JOB_COUNT_C = CNT_W'(JOB_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(JOB_COUNT - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_COMMIT = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [BURST_W-1:0]    best_rem_reg, best_rem_next;
    logic [BURST_W-1:0]    best_key_reg, best_key_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]      cursor_reg, cursor_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    policy_t               policy_reg;
    logic [SLICE_W-1:0]    slice_reg;

    logic                  res_disp_reg, res_disp_next;
    logic [INDEX_W-1:0]    res_job_reg, res_job_next;
    logic [TIME_W-1:0]     res_start_reg, res_start_next;
    logic [BURST_W-1:0]    res_run_reg, res_run_next;
    logic                  res_fin_reg, res_fin_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_disp_reg, out_disp_next;
    logic [INDEX_W-1:0]    out_job_reg, out_job_next;
    logic [TIME_W-1:0]     out_start_reg, out_start_next;
    logic [BURST_W-1:0]    out_run_reg, out_run_next;
    logic                  out_fin_reg, out_fin_next;
    logic                  out_over_reg, out_over_next;

    logic [INDEX_W-1:0]    ld_index;
    logic [BURST_W-1:0]    ld_burst;
    logic [PRIO_W-1:0]     ld_prio;
    logic                  s_accept;

    logic [IDX_W-1:0]      cnt_idx;
    logic                  issue;
    logic [IDX_W-1:0]      base_idx;
    logic [IDX_W:0]        addr_sum;
    logic [IDX_W-1:0]      rd_addr;

    logic                  burst_we, rem_we;
    logic [IDX_W-1:0]      burst_waddr, rem_waddr;
    logic [BURST_W-1:0]    burst_wdata, rem_wdata;
    logic [PRIO_W-1:0]     prio_wdata;
    logic [BURST_W+PRIO_W-1:0] job_rd;
    logic [BURST_W-1:0]    burst_rd, rem_rd;
    logic [PRIO_W-1:0]     prio_rd;

    logic [BURST_W-1:0]    cand_key;
    logic                  use_key;
    logic [SLICE_W-1:0]    slice_eff;
    logic [BURST_W-1:0]    run_amt;
    logic [TIME_W:0]       elapsed_sum;

    assign ld_index = s_tdata[INDEX_W-1:0];
    assign ld_burst = s_tdata[INDEX_W +: BURST_W];
    assign ld_prio  = s_tdata[INDEX_W + BURST_W +: PRIO_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign issue    = (cnt_reg != JOB_COUNT_C);
    assign base_idx = (state_reg == ST_SCAN && policy_reg == POL_RR) ? cursor_reg : '0;
    assign addr_sum = (IDX_W + 1)'(base_idx) + (IDX_W + 1)'(cnt_idx);
    assign rd_addr  = (addr_sum >= JOB_COUNT_X) ? IDX_W'(addr_sum - JOB_COUNT_X)
                                                : addr_sum[IDX_W-1:0];

    assign use_key   = (policy_reg == POL_SJF) || (policy_reg == POL_PRIO);
    assign cand_key  = (policy_reg == POL_SJF) ? burst_rd : prio_rd;
    assign slice_eff = (slice_reg == '0) ? SLICE_RESET : slice_reg;
    assign run_amt   = (policy_reg == POL_RR && best_rem_reg > slice_eff) ? slice_eff
                                                                         : best_rem_reg;
    assign elapsed_sum = (TIME_W + 1)'(elapsed_reg) + (TIME_W + 1)'(run_amt);

    assign burst_rd = job_rd[BURST_W-1:0];
    assign prio_rd  = job_rd[BURST_W +: PRIO_W];

    cjds_ram #(.WIDTH(BURST_W + PRIO_W), .DEPTH(JOB_COUNT)) u_job_ram (
        .aclk  (aclk),
        .we    (burst_we),
        .waddr (burst_waddr),
        .wdata ({prio_wdata, burst_wdata}),
        .raddr (rd_addr),
        .rdata (job_rd)
    );

    cjds_ram #(.WIDTH(BURST_W), .DEPTH(JOB_COUNT)) u_rem_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (rd_addr),
        .rdata (rem_rd)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_rem_next  = best_rem_reg;
        best_key_next  = best_key_reg;
        elapsed_next   = elapsed_reg;
        cursor_next    = cursor_reg;
        live_next      = live_reg;
        res_disp_next  = res_disp_reg;
        res_job_next   = res_job_reg;
        res_start_next = res_start_reg;
        res_run_next   = res_run_reg;
        res_fin_next   = res_fin_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_disp_next  = out_disp_reg;
        out_job_next   = out_job_reg;
        out_start_next = out_start_reg;
        out_run_next   = out_run_reg;
        out_fin_next   = out_fin_reg;
        out_over_next  = out_over_reg;

        burst_we    = 1'b0;
        burst_waddr = IDX_W'(ld_index);
        burst_wdata = ld_burst;
        prio_wdata  = ld_prio;
        rem_we      = 1'b0;
        rem_waddr   = pend_idx_reg;
        rem_wdata   = burst_rd;

        unique case (state_reg)
            ST_CLEAR: begin
                burst_we    = 1'b1;
                burst_waddr = cnt_idx;
                burst_wdata = '0;
                prio_wdata  = '0;
                rem_we      = 1'b1;
                rem_waddr   = cnt_idx;
                rem_wdata   = '0;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_idx == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    res_disp_next  = 1'b0;
                    res_job_next   = '0;
                    res_start_next = '0;
                    res_run_next   = '0;
                    res_fin_next   = 1'b0;
                    cnt_next       = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    unique case (mode_t'(s_tuser))
                        MODE_LOAD: begin
                            burst_we   = (32'(ld_index) < JOB_COUNT);
                            state_next = ST_EMIT;
                        end
                        MODE_RESTART: begin
                            elapsed_next = '0;
                            cursor_next  = '0;
                            live_next    = '0;
                            state_next   = ST_SWEEP;
                        end
                        MODE_DISPATCH: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                pend_next     = issue;
                pend_idx_next = rd_addr;
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    rem_we = 1'b1;
                    if (burst_rd != '0) begin
                        live_next = live_reg + CNT_W'(1);
                    end
                end
                if (!issue && pend_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN: begin
                pend_next     = issue;
                pend_idx_next = rd_addr;
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (pend_reg && rem_rd != '0 &&
                    (!found_reg || (use_key && cand_key < best_key_reg))) begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_rem_next = rem_rd;
                    best_key_next = cand_key;
                end
                if (!issue && pend_reg) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (found_reg) begin
                    rem_we         = 1'b1;
                    rem_waddr      = best_idx_reg;
                    rem_wdata      = best_rem_reg - run_amt;
                    elapsed_next   = (elapsed_sum > (TIME_W + 1)'(ELAPSED_MAX))
                                     ? ELAPSED_MAX : elapsed_sum[TIME_W-1:0];
                    res_disp_next  = 1'b1;
                    res_job_next   = INDEX_W'(best_idx_reg);
                    res_start_next = elapsed_reg;
                    res_run_next   = run_amt;
                    res_fin_next   = (run_amt == best_rem_reg);
                    if (run_amt == best_rem_reg) begin
                        live_next = live_reg - CNT_W'(1);
                    end
                    if (policy_reg == POL_RR) begin
                        cursor_next = (best_idx_reg == LAST_IDX) ? '0
                                                                 : best_idx_reg + IDX_W'(1);
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_disp_next  = res_disp_reg;
                    out_job_next   = res_job_reg;
                    out_start_next = res_start_reg;
                    out_run_next   = res_run_reg;
                    out_fin_next   = res_fin_reg;
                    out_over_next  = (live_reg == '0);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            elapsed_reg   <= '0;
            cursor_reg    <= '0;
            live_reg      <= '0;
            policy_reg    <= POL_FCFS;
            slice_reg     <= SLICE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            elapsed_reg   <= elapsed_next;
            cursor_reg    <= cursor_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_POLICY: policy_reg <= policy_t'(cfg_data[POLICY_W-1:0]);
                    CFG_SLICE:  slice_reg  <= cfg_data[SLICE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_rem_reg  <= best_rem_next;
        best_key_reg  <= best_key_next;
        res_disp_reg  <= res_disp_next;
        res_job_reg   <= res_job_next;
        res_start_reg <= res_start_next;
        res_run_reg   <= res_run_next;
        res_fin_reg   <= res_fin_next;
        out_disp_reg  <= out_disp_next;
        out_job_reg   <= out_job_next;
        out_start_reg <= out_start_next;
        out_run_reg   <= out_run_next;
        out_fin_reg   <= out_fin_next;
        out_over_reg  <= out_over_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_disp_reg;
    assign m_tdata    = {{(M_TDATA_W - M_PAY_W){1'b0}}, out_over_reg, out_fin_reg,
                         out_run_reg, out_start_reg, out_job_reg};

`ifndef SYNTHESIS
    // The count of jobs with work left can never exceed the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= JOB_COUNT_C)
        else $error("live job count exceeds table size");

    // A job picked by the scan always has remaining time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && found_reg) |-> (best_rem_reg != '0))
        else $error("picked job has no remaining time");

    // A dispatch that leaves work on its job cannot report the schedule as over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_disp_reg && !out_fin_reg) |-> !out_over_reg)
        else $error("schedule over while dispatched job still has work");
`endif

endmodule

`default_nettype wire

// File: rtl/cjds_ram.sv
`default_nettype none

module cjds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: tb/cjds_dispatch_checker.sv
`timescale 1ns / 100ps

module cjds_dispatch_checker #(
    parameter int JOB_COUNT = cjds_pkg::JOB_COUNT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [cjds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cjds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [cjds_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [cjds_pkg::MODE_W-1:0]      s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [cjds_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [0:0]                       m_tuser,
    output int unsigned                           fail_count,
    output int unsigned                           pending
);

    import cjds_pkg::*;

    localparam int OFS_TIME = INDEX_W;
    localparam int OFS_RUN  = OFS_TIME + TIME_W;
    localparam int OFS_FIN  = OFS_RUN + BURST_W;
    localparam int OFS_OVER = OFS_FIN + 1;

    typedef struct packed {
        logic               dispatch_valid;
        logic [INDEX_W-1:0] chosen_job;
        logic [TIME_W-1:0]  start_time;
        logic [BURST_W-1:0] run_amount;
        logic               job_finished;
        logic               schedule_over;
    } dispatch_rec_t;

    dispatch_rec_t      due_q[$];
    logic [BURST_W-1:0] burst_tbl[JOB_COUNT];
    logic [PRIO_W-1:0]  prio_tbl[JOB_COUNT];
    logic [BURST_W-1:0] left_tbl[JOB_COUNT];
    logic [TIME_W-1:0]  clock_now;
    logic [INDEX_W-1:0] rr_next;
    policy_t            pol;
    logic [SLICE_W-1:0] slice;

    function automatic dispatch_rec_t schedule_item(
        input logic [MODE_W-1:0]  mode,
        input logic [INDEX_W-1:0] idx,
        input logic [BURST_W-1:0] burst,
        input logic [PRIO_W-1:0]  prio
    );
        dispatch_rec_t      r;
        int                 pick;
        int                 cand;
        logic [BURST_W-1:0] run;
        logic [SLICE_W-1:0] sl;
        logic [TIME_W:0]    sum;
        r    = '0;
        pick = -1;
        case (mode)
            MODE_LOAD: begin
                if (idx < JOB_COUNT) begin
                    burst_tbl[idx] = burst;
                    prio_tbl[idx]  = prio;
                end
            end
            MODE_RESTART: begin
                for (int i = 0; i < JOB_COUNT; i++) left_tbl[i] = burst_tbl[i];
                clock_now = '0;
                rr_next   = '0;
            end
            MODE_DISPATCH: begin
                if (pol == POL_RR) begin
                    for (int n = 0; n < JOB_COUNT; n++) begin
                        cand = (rr_next + n) % JOB_COUNT;
                        if (pick < 0 && left_tbl[cand] != 0) pick = cand;
                    end
                end else begin
                    for (int i = 0; i < JOB_COUNT; i++) begin
                        if (left_tbl[i] != 0) begin
                            if (pick < 0) pick = i;
                            else if (pol == POL_SJF && burst_tbl[i] < burst_tbl[pick]) pick = i;
                            else if (pol == POL_PRIO && prio_tbl[i] < prio_tbl[pick]) pick = i;
                        end
                    end
                end
                if (pick >= 0) begin
                    run = left_tbl[pick];
                    if (pol == POL_RR) begin
                        sl = (slice == 0) ? SLICE_W'(1) : slice;
                        if (run > sl) run = sl;
                        rr_next = INDEX_W'((pick + 1) % JOB_COUNT);
                    end
                    r.dispatch_valid = 1'b1;
                    r.chosen_job     = INDEX_W'(pick);
                    r.start_time     = clock_now;
                    r.run_amount     = run;
                    sum       = clock_now + run;
                    clock_now = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[TIME_W-1:0];
                    left_tbl[pick] = left_tbl[pick] - run;
                    r.job_finished = (left_tbl[pick] == 0);
                end
            end
            default: begin
            end
        endcase
        r.schedule_over = 1'b1;
        for (int i = 0; i < JOB_COUNT; i++) if (left_tbl[i] != 0) r.schedule_over = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        dispatch_rec_t got;
        dispatch_rec_t want;
        if (!aresetn) begin
            for (int i = 0; i < JOB_COUNT; i++) begin
                burst_tbl[i] = '0;
                prio_tbl[i]  = '0;
                left_tbl[i]  = '0;
            end
            clock_now = '0;
            rr_next   = '0;
            pol       = POL_FCFS;
            slice     = SLICE_RESET;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.dispatch_valid = m_tuser[0];
                got.chosen_job     = m_tdata[0 +: INDEX_W];
                got.start_time     = m_tdata[OFS_TIME +: TIME_W];
                got.run_amount     = m_tdata[OFS_RUN +: BURST_W];
                got.job_finished   = m_tdata[OFS_FIN];
                got.schedule_over  = m_tdata[OFS_OVER];
                if (due_q.size() == 0) begin
                    $error("result item arrived with none expected");
                    fail_count++;
                end else begin
                    want = due_q.pop_front();
                    check_field("dispatch_valid", want.dispatch_valid, got.dispatch_valid);
                    check_field("chosen_job", want.chosen_job, got.chosen_job);
                    check_field("start_time", want.start_time, got.start_time);
                    check_field("run_amount", want.run_amount, got.run_amount);
                    check_field("job_finished", want.job_finished, got.job_finished);
                    check_field("schedule_over", want.schedule_over, got.schedule_over);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POLICY: pol   = policy_t'(cfg_data[POLICY_W-1:0]);
                    CFG_SLICE:  slice = cfg_data[SLICE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                due_q.push_back(schedule_item(s_tuser, s_tdata[0 +: INDEX_W],
                                              s_tdata[INDEX_W +: BURST_W],
                                              s_tdata[INDEX_W + BURST_W +: PRIO_W]));
            end
        end
        pending <= due_q.size();
    end

endmodule

// File: tb/tb_cpu_job_dispatch_scheduler_unit.sv
`timescale 1ns / 100ps

module tb_cpu_job_dispatch_scheduler_unit;
    import cjds_pkg::*;

    localparam int TARGET_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_TAIL   = 80;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_POLICY;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    int unsigned            fail_count;
    int unsigned            pending;

    bit          idle_on      = 1'b1;
    int unsigned hold_req_cnt = 0;
    int unsigned hold_seen    = 0;
    int unsigned rx_wait      = 0;
    int unsigned cycles       = 0;
    int unsigned sent         = 0;

    cpu_job_dispatch_scheduler_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cjds_dispatch_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver either serves a long hold-off request, sits out a short stall burst,
    // or accepts.
    always @(posedge aclk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen <= hold_req_cnt;
            rx_wait   <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_wait  <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                             input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'({prio, burst, idx});
        do @(posedge aclk); while (!s_tready);
        if (mode != MODE_UNUSED) sent++;
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_config(input policy_t pol, input logic [SLICE_W-1:0] slice);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_data  <= CFG_DATA_W'(pol);
        @(posedge aclk);
        cfg_index <= CFG_SLICE;
        cfg_data  <= CFG_DATA_W'(slice);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [BURST_W-1:0] pick_burst(input bit brief_bursts);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return brief_bursts ? BURST_W'(12) : BURST_W'(255);
            default: return brief_bursts ? BURST_W'($urandom_range(1, 12))
                                         : BURST_W'($urandom_range(1, 255));
        endcase
    endfunction

    initial begin
        int          phase;
        int          nload;
        int          ndisp;
        int          roll;
        policy_t     pol_now;
        logic [7:0]  slice_now;
        bit          brief_bursts;

        phase = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(MODE_DISPATCH, 5'd0, 8'd0, 8'd0);
        send_item(MODE_UNUSED, 5'd31, 8'hFF, 8'hFF);
        send_item(MODE_LOAD, 5'd0, 8'd255, 8'd255);
        send_item(MODE_LOAD, 5'd31, 8'd1, 8'd0);
        send_item(MODE_LOAD, 5'd5, 8'd0, 8'd9);
        send_item(MODE_LOAD, 5'd12, 8'd3, 8'd255);
        send_item(MODE_LOAD, 5'd20, 8'd3, 8'd255);
        send_item(MODE_DISPATCH, 5'd0, 8'd0, 8'd0);
        send_item(MODE_RESTART, 5'd0, 8'd0, 8'd0);
        repeat (5) send_item(MODE_DISPATCH, 5'd0, 8'd0, 8'd0);

        wait_quiet();
        set_config(POL_SJF, 8'd1);
        send_item(MODE_RESTART, 5'd31, 8'hFF, 8'hFF);
        repeat (3) send_item(MODE_DISPATCH, 5'd31, 8'hFF, 8'hFF);

        wait_quiet();
        set_config(POL_PRIO, 8'd1);
        send_item(MODE_RESTART, 5'd0, 8'd0, 8'd0);
        repeat (2) send_item(MODE_DISPATCH, 5'd0, 8'd0, 8'd0);

        wait_quiet();
        set_config(POL_RR, 8'd0);
        send_item(MODE_RESTART, 5'd0, 8'd0, 8'd0);
        repeat (3) send_item(MODE_DISPATCH, 5'd0, 8'd0, 8'd0);

        while (sent < TARGET_ITEMS) begin
            phase++;
            wait_quiet();
            idle_on <= (sent + QUIET_TAIL < TARGET_ITEMS) && ($urandom_range(0, 3) != 0);
            pol_now = policy_t'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       slice_now = 8'd0;
                1:       slice_now = 8'd1;
                2:       slice_now = 8'd255;
                default: slice_now = 8'($urandom_range(2, 254));
            endcase
            set_config(pol_now, slice_now);
            if (phase == 3 || phase == 9) hold_req_cnt <= hold_req_cnt + 1;
            brief_bursts = (pol_now == POL_RR) && (slice_now < 16);

            nload = $urandom_range(0, 10);
            repeat (nload) send_item(MODE_LOAD, 5'($urandom_range(0, 31)),
                                     pick_burst(brief_bursts), 8'($urandom));
            send_item(MODE_RESTART, 5'($urandom), 8'($urandom), 8'($urandom));

            ndisp = (pol_now == POL_RR) ? 2 * nload + $urandom_range(0, 4)
                                        : nload + $urandom_range(0, 3);
            if (ndisp > 30) ndisp = 30;
            repeat (ndisp) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    send_item(MODE_UNUSED, 5'($urandom), 8'($urandom), 8'($urandom));
                end else if (roll == 1) begin
                    send_item(MODE_LOAD, 5'($urandom), pick_burst(brief_bursts),
                              8'($urandom));
                end else if (roll == 2) begin
                    send_item(MODE_RESTART, 5'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    send_item(MODE_DISPATCH, 5'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end

        wait_quiet();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
